[hdl/dtsr_pkg.sv]
`timescale 1ns / 1ps

package dtsr_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    localparam logic [31:0] DEPTH_FAR = 32'h7FFF_FFFF;
    localparam int          DIV_STEPS = 48;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd_issue;
        logic rd_capture;
        logic row_next;
        logic div_start;
        logic col_init;
        logic pix;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic clr_last;
        logic draw_empty;
        logic rows_done;
        logic row_neg;
        logic div_done;
        logic col_empty;
        logic col_last;
    } t_sts;

    function automatic logic [7:0] grey_to_rgb332(input logic [7:0] g);
        grey_to_rgb332 = (g & 8'hE0) | ((g & 8'hE0) >> 3) | ((g & 8'hC0) >> 6);
    endfunction

endpackage

[hdl/dtsr_ram.sv]
`timescale 1ns / 1ps

module dtsr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hdl/dtsr_div.sv]
`timescale 1ns / 1ps

module dtsr_div import dtsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [47:0]      r_q;
    logic [31:0]      r_b;
    logic             r_neg;
    logic             r_zero;

    logic signed [47:0] w_a;
    logic [47:0]        w_amag;
    logic [31:0]        w_bmag;
    logic [32:0]        w_shift;
    logic [32:0]        w_trial;

    // dividend is the numerator scaled by 2^16
    assign w_a     = {i_num, 16'h0000};
    assign w_amag  = w_a[47] ? 48'(-w_a) : w_a;
    assign w_bmag  = i_den[31] ? 32'(-i_den) : i_den;
    assign w_shift = {r_rem, r_q[47]};
    assign w_trial = w_shift - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= w_amag;
                r_b    <= w_bmag;
                r_neg  <= i_num[31] ^ i_den[31];
                r_zero <= (i_den == 32'h0);
            end else if (r_busy) begin
                if (!w_trial[32]) begin
                    r_rem <= w_trial[31:0];
                    r_q   <= {r_q[46:0], 1'b1};
                end else begin
                    r_rem <= w_shift[31:0];
                    r_q   <= {r_q[46:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // truncated quotient, saturated to 32 bits
    always_comb begin
        if (r_zero) begin
            o_quot = 32'h0;
        end else if (!r_neg) begin
            o_quot = (|r_q[47:31]) ? 32'h7FFF_FFFF : r_q[31:0];
        end else begin
            o_quot = (r_q > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-r_q[31:0]);
        end
    end

    assign o_done = r_done;

endmodule

[hdl/dtsr_datapath.sv]
`timescale 1ns / 1ps

module dtsr_datapath import dtsr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_top_row,
    input  logic [31:0] i_bottom_row,
    input  logic [31:0] i_left_x,
    input  logic [31:0] i_left_x_slope,
    input  logic [31:0] i_left_z,
    input  logic [31:0] i_left_z_slope,
    input  logic [31:0] i_right_x,
    input  logic [31:0] i_right_x_slope,
    input  logic [31:0] i_right_z,
    input  logic [31:0] i_right_z_slope,
    input  logic [7:0]  i_shade,
    output logic [7:0]  o_pixel_colour,
    output logic [31:0] o_pixel_depth,
    output logic [16:0] o_pixels_written
);

    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int COL_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int ROW_W  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam logic signed [17:0] COL_LAST = 18'(SCREEN_WIDTH - 1);
    localparam logic signed [17:0] ROW_LAST = 18'(SCREEN_HEIGHT - 1);

    t_op                r_op;
    logic [31:0]        r_top, r_bot;
    logic [31:0]        r_lx, r_lxs, r_lz, r_lzs;
    logic [31:0]        r_rx, r_rxs, r_rz, r_rzs;
    logic [7:0]         r_colour;
    logic signed [17:0] r_row;
    logic [16:0]        r_n;
    logic [15:0]        r_nmax;
    logic [31:0]        r_dzdx;
    logic [COL_W-1:0]   r_col, r_cend;
    logic [31:0]        r_z;
    logic               r_p_v;
    logic [ADDR_W-1:0]  r_p_addr;
    logic [31:0]        r_p_z;
    logic [ADDR_W-1:0]  r_addr;
    logic [16:0]        r_count;
    logic [7:0]         r_res_colour;
    logic [31:0]        r_res_depth;
    logic [7:0]         r_o_colour;
    logic [31:0]        r_o_depth;
    logic [16:0]        r_o_count;

    logic [32:0]        w_span;
    logic [31:0]        w_xs;
    logic               w_rx_lt;
    logic [32:0]        w_xdiff;
    logic signed [17:0] w_ix0, w_cend;
    logic [16:0]        w_klo;
    logic [COL_W-1:0]   w_cstart, w_cend_cl;
    logic [48:0]        w_prod;
    logic [ADDR_W-1:0]  w_pix_addr, w_rd_addr, w_raddr, w_waddr;
    logic signed [17:0] w_rd_r, w_rd_c;
    logic               w_rd_in;
    logic               w_pass, w_we;
    logic [7:0]         w_rd_colour;
    logic [31:0]        w_rd_depth;
    logic               w_div_done;
    logic [31:0]        w_div_quot;

    assign w_span = {i_bottom_row[31], i_bottom_row} - {i_top_row[31], i_top_row};

    // span setup for the current row
    assign w_xs      = {r_lx[31:16], 16'h0000};
    assign w_rx_lt   = $signed(r_rx) < $signed(w_xs);
    assign w_xdiff   = {r_rx[31], r_rx} - {w_xs[31], w_xs};
    assign w_ix0     = {{2{r_lx[31]}}, r_lx[31:16]};
    assign w_cend    = w_ix0 + $signed({2'b00, w_xdiff[31:16]});
    assign w_klo     = w_ix0[17] ? 17'(-w_ix0) : 17'h0;
    assign w_cstart  = w_ix0[17] ? '0 : w_ix0[COL_W-1:0];
    assign w_cend_cl = (w_cend > COL_LAST) ? COL_LAST[COL_W-1:0] : w_cend[COL_W-1:0];
    assign w_prod    = {32'h0, w_klo} * {17'h0, r_dzdx};

    assign w_pix_addr = ADDR_W'(r_row[ROW_W-1:0]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(r_col);

    assign w_rd_r    = {{2{r_top[31]}}, r_top[31:16]};
    assign w_rd_c    = {{2{r_lx[31]}}, r_lx[31:16]};
    assign w_rd_in   = !w_rd_r[17] && !w_rd_c[17] && (w_rd_r <= ROW_LAST) && (w_rd_c <= COL_LAST);
    assign w_rd_addr = ADDR_W'(r_top[16 +: ROW_W]) * ADDR_W'(SCREEN_WIDTH)
                     + ADDR_W'(r_lx[16 +: COL_W]);

    assign w_raddr = i_cmd.rd_issue ? w_rd_addr : w_pix_addr;
    assign w_pass  = r_p_v && ($signed(r_p_z) < $signed(w_rd_depth));
    assign w_we    = i_cmd.clr_wr || w_pass;
    assign w_waddr = i_cmd.clr_wr ? r_addr : r_p_addr;

    dtsr_ram #(.WIDTH(32), .DEPTH(PIXELS), .ADDR_W(ADDR_W)) u_depth_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_cmd.clr_wr ? DEPTH_FAR : r_p_z),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_depth)
    );

    dtsr_ram #(.WIDTH(8), .DEPTH(PIXELS), .ADDR_W(ADDR_W)) u_colour_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_cmd.clr_wr ? 8'h00 : r_colour),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_colour)
    );

    dtsr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (r_rz - r_lz),
        .i_den  (r_rx - r_lx),
        .o_done (w_div_done),
        .o_quot (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= i_cmd.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= t_op'(i_op);
            r_top        <= i_top_row;
            r_bot        <= i_bottom_row;
            r_lx         <= i_left_x;
            r_lxs        <= i_left_x_slope;
            r_lz         <= i_left_z;
            r_lzs        <= i_left_z_slope;
            r_rx         <= i_right_x;
            r_rxs        <= i_right_x_slope;
            r_rz         <= i_right_z;
            r_rzs        <= i_right_z_slope;
            r_colour     <= grey_to_rgb332(i_shade);
            r_row        <= {{2{i_top_row[31]}}, i_top_row[31:16]};
            r_n          <= '0;
            r_nmax       <= w_span[31:16];
            r_count      <= '0;
            r_res_colour <= '0;
            r_res_depth  <= '0;
            r_addr       <= '0;
        end
        if (i_cmd.clr_wr) begin
            r_addr <= r_addr + 1'b1;
        end
        if (i_cmd.row_next) begin
            r_row <= r_row + 18'sd1;
            r_n   <= r_n + 1'b1;
            r_lx  <= r_lx + r_lxs;
            r_lz  <= r_lz + r_lzs;
            r_rx  <= r_rx + r_rxs;
            r_rz  <= r_rz + r_rzs;
        end
        if (w_div_done) begin
            r_dzdx <= w_div_quot;
        end
        if (i_cmd.col_init) begin
            r_col  <= w_cstart;
            r_cend <= w_cend_cl;
            r_z    <= r_lz + w_prod[31:0];
        end
        if (i_cmd.pix) begin
            r_col    <= r_col + 1'b1;
            r_z      <= r_z + r_dzdx;
            r_p_addr <= w_pix_addr;
            r_p_z    <= r_z;
        end
        if (w_pass) begin
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.rd_capture && w_rd_in) begin
            r_res_colour <= w_rd_colour;
            r_res_depth  <= w_rd_depth;
        end
        if (i_cmd.res_load) begin
            r_o_colour <= r_res_colour;
            r_o_depth  <= r_res_depth;
            r_o_count  <= r_count;
        end
    end

    always_comb begin
        o_sts.op         = r_op;
        o_sts.clr_last   = (r_addr == ADDR_W'(PIXELS - 1));
        o_sts.draw_empty = $signed(r_bot) < $signed(r_top);
        o_sts.rows_done  = ({1'b0, r_nmax} < r_n) || (r_row > ROW_LAST);
        o_sts.row_neg    = r_row[17];
        o_sts.div_done   = w_div_done;
        o_sts.col_empty  = w_rx_lt || w_cend[17] || (w_ix0 > COL_LAST);
        o_sts.col_last   = (r_col == r_cend);
    end

    assign o_pixel_colour   = r_o_colour;
    assign o_pixel_depth    = r_o_depth;
    assign o_pixels_written = r_o_count;

endmodule

[hdl/dtsr_ctrl.sv]
`timescale 1ns / 1ps

module dtsr_ctrl import dtsr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_DISPATCH  = 11'b000_0000_0010,
        S_CLEAR     = 11'b000_0000_0100,
        S_READ_REQ  = 11'b000_0000_1000,
        S_READ_DATA = 11'b000_0001_0000,
        S_ROW_CHK   = 11'b000_0010_0000,
        S_ROW_DIV   = 11'b000_0100_0000,
        S_COL_SETUP = 11'b000_1000_0000,
        S_PIXEL     = 11'b001_0000_0000,
        S_DRAIN     = 11'b010_0000_0000,
        S_DONE      = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_CLEAR: n_state = S_CLEAR;
                    OP_DRAW:  n_state = i_sts.draw_empty ? S_DONE : S_ROW_CHK;
                    OP_READ:  n_state = S_READ_REQ;
                    default:  n_state = S_DONE;
                endcase
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_READ_REQ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_READ_DATA;
            end
            S_READ_DATA: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_DONE;
            end
            S_ROW_CHK: begin
                if (i_sts.rows_done) begin
                    n_state = S_DONE;
                end else if (i_sts.row_neg) begin
                    o_cmd.row_next = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_ROW_DIV;
                end
            end
            S_ROW_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_COL_SETUP;
                end
            end
            S_COL_SETUP: begin
                if (i_sts.col_empty) begin
                    o_cmd.row_next = 1'b1;
                    n_state        = S_ROW_CHK;
                end else begin
                    o_cmd.col_init = 1'b1;
                    n_state        = S_PIXEL;
                end
            end
            S_PIXEL: begin
                o_cmd.pix = 1'b1;
                if (i_sts.col_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.row_next = 1'b1;
                n_state        = S_ROW_CHK;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hdl/depth_tested_span_rasterizer.sv]
`timescale 1ns / 1ps

// Trapezoid span fill into a SCREEN_WIDTH x SCREEN_HEIGHT RGB332 colour store
// and Q16.16 depth store, one request at a time. Both stores are single
// write / single read RAMs. A clear must come before any draw or read. A draw
// whose bottom_row lies above top_row does no rows; otherwise each row that
// lies above the screen is skipped, and any other row runs the bit-serial
// 48-step z slope divider and then, when the span reaches the screen, tests
// one in-screen pixel of the span per cycle.
// The result register frees the input side as soon as a result is handed over.
module depth_tested_span_rasterizer import dtsr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_top_row,
    input  logic [31:0] i_bottom_row,
    input  logic [31:0] i_left_x,
    input  logic [31:0] i_left_x_slope,
    input  logic [31:0] i_left_z,
    input  logic [31:0] i_left_z_slope,
    input  logic [31:0] i_right_x,
    input  logic [31:0] i_right_x_slope,
    input  logic [31:0] i_right_z,
    input  logic [31:0] i_right_z_slope,
    input  logic [7:0]  i_shade,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_pixel_colour,
    output logic [31:0] o_pixel_depth,
    output logic [16:0] o_pixels_written
);

    t_cmd w_cmd;
    t_sts w_sts;

    dtsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_cmd      (w_cmd)
    );

    dtsr_datapath #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_op            (i_op),
        .i_top_row       (i_top_row),
        .i_bottom_row    (i_bottom_row),
        .i_left_x        (i_left_x),
        .i_left_x_slope  (i_left_x_slope),
        .i_left_z        (i_left_z),
        .i_left_z_slope  (i_left_z_slope),
        .i_right_x       (i_right_x),
        .i_right_x_slope (i_right_x_slope),
        .i_right_z       (i_right_z),
        .i_right_z_slope (i_right_z_slope),
        .i_shade         (i_shade),
        .o_pixel_colour  (o_pixel_colour),
        .o_pixel_depth   (o_pixel_depth),
        .o_pixels_written(o_pixels_written)
    );

endmodule

[hdl/dtsr_checker.sv]
`timescale 1ns / 1ps

module dtsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_op,
    input logic [31:0] i_top_row,
    input logic [31:0] i_bottom_row,
    input logic [31:0] i_left_x,
    input logic [31:0] i_left_x_slope,
    input logic [31:0] i_left_z,
    input logic [31:0] i_left_z_slope,
    input logic [31:0] i_right_x,
    input logic [31:0] i_right_x_slope,
    input logic [31:0] i_right_z,
    input logic [31:0] i_right_z_slope,
    input logic [7:0]  i_shade,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_pixel_colour,
    input logic [31:0] o_pixel_depth,
    input logic [16:0] o_pixels_written
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_depth)
            && $stable(o_pixel_colour) && $stable(o_pixels_written))
        else $error("result changed while stalled");

    // one request in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    // draw count and read data never come together
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_pixels_written != 17'h0) |->
            (o_pixel_colour == 8'h00) && (o_pixel_depth == 32'h0))
        else $error("mixed result fields");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind depth_tested_span_rasterizer dtsr_checker u_dtsr_checker (.*);

[verif/span_checker.sv]
`timescale 1ns / 1ps

module span_checker import dtsr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_top_row,
    input  logic [31:0] i_bottom_row,
    input  logic [31:0] i_left_x,
    input  logic [31:0] i_left_x_slope,
    input  logic [31:0] i_left_z,
    input  logic [31:0] i_left_z_slope,
    input  logic [31:0] i_right_x,
    input  logic [31:0] i_right_x_slope,
    input  logic [31:0] i_right_z,
    input  logic [31:0] i_right_z_slope,
    input  logic [7:0]  i_shade,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_pixel_colour,
    input  logic [31:0] i_pixel_depth,
    input  logic [16:0] i_pixels_written,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_pixels_total
);

    typedef struct packed {
        logic [7:0]  colour;
        logic [31:0] depth;
        logic [16:0] written;
    } t_span_result;

    logic [7:0]  frame_colour [SCREEN_WIDTH*SCREEN_HEIGHT];
    logic [31:0] frame_depth  [SCREEN_WIDTH*SCREEN_HEIGHT];
    t_span_result expected_results [$];

    initial begin
        o_fail_count   = 0;
        o_pixels_total = 0;
    end

    assign o_pending = expected_results.size();

    function automatic longint floor_q16(input longint v);
        if (v >= 0) return v >>> 16;
        return -((-v + 65535) >>> 16);
    endfunction

    function automatic logic [31:0] z_slope(input logic [31:0] num, input logic [31:0] den);
        longint a;
        longint b;
        longint q;
        a = longint'($signed(num)) * 65536;
        b = longint'($signed(den));
        if (b == 0) return 32'd0;
        q = a / b;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic logic [16:0] fill_trapezoid();
        longint y1, y2, iy0, nmax, nlo, nhi, row, xs, rx, ix0, kmax, klo, khi, idx;
        logic [31:0] lx, lz, rxu, rz, dzdx, z;
        logic [7:0]  g, col;
        logic [16:0] count;
        count = '0;
        y1 = longint'($signed(i_top_row));
        y2 = longint'($signed(i_bottom_row));
        g = i_shade;
        col = (g & 8'hE0) | ((g & 8'hE0) >> 3) | ((g & 8'hC0) >> 6);
        if (y2 < y1) return '0;
        iy0 = floor_q16(y1);
        nmax = (y2 - y1) >>> 16;
        nlo = (iy0 < 0) ? -iy0 : 0;
        nhi = nmax;
        if (nhi > SCREEN_HEIGHT - 1 - iy0) nhi = SCREEN_HEIGHT - 1 - iy0;
        for (longint n = nlo; n <= nhi; n++) begin
            lx  = i_left_x + 32'(n) * i_left_x_slope;
            lz  = i_left_z + 32'(n) * i_left_z_slope;
            rxu = i_right_x + 32'(n) * i_right_x_slope;
            rz  = i_right_z + 32'(n) * i_right_z_slope;
            row = iy0 + n;
            xs = longint'($signed({lx[31:16], 16'h0}));
            rx = longint'($signed(rxu));
            dzdx = (lx != rxu) ? z_slope(rz - lz, rxu - lx) : 32'd0;
            if (rx < xs) continue;
            ix0 = floor_q16(xs);
            kmax = (rx - xs) >>> 16;
            klo = (ix0 < 0) ? -ix0 : 0;
            khi = kmax;
            if (khi > SCREEN_WIDTH - 1 - ix0) khi = SCREEN_WIDTH - 1 - ix0;
            for (longint k = klo; k <= khi; k++) begin
                idx = row * SCREEN_WIDTH + ix0 + k;
                z = lz + 32'(k) * dzdx;
                if ($signed(z) < $signed(frame_depth[idx])) begin
                    frame_depth[idx]  = z;
                    frame_colour[idx] = col;
                    count++;
                end
            end
        end
        return count;
    endfunction

    always @(posedge i_clk) begin
        t_span_result exp_r;
        t_span_result got_r;
        longint r, c;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            exp_r = '0;
            case (t_op'(i_op))
                OP_CLEAR: begin
                    foreach (frame_depth[i]) begin
                        frame_depth[i]  = DEPTH_FAR;
                        frame_colour[i] = '0;
                    end
                end
                OP_DRAW: begin
                    exp_r.written = fill_trapezoid();
                    o_pixels_total <= o_pixels_total + exp_r.written;
                end
                OP_READ: begin
                    r = floor_q16(longint'($signed(i_top_row)));
                    c = floor_q16(longint'($signed(i_left_x)));
                    if (r >= 0 && r < SCREEN_HEIGHT && c >= 0 && c < SCREEN_WIDTH) begin
                        exp_r.colour = frame_colour[r*SCREEN_WIDTH+c];
                        exp_r.depth  = frame_depth[r*SCREEN_WIDTH+c];
                    end
                end
                default: ;
            endcase
            expected_results.push_back(exp_r);
        end
        if (i_rst_n && i_out_valid && i_out_ready) begin
            got_r = '{i_pixel_colour, i_pixel_depth, i_pixels_written};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result colour=%h depth=%h written=%0d", $time,
                         got_r.colour, got_r.depth, got_r.written);
                o_fail_count <= o_fail_count + 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (got_r !== exp_r) begin
                    $display("%0t: mismatch expected colour=%h depth=%h written=%0d",
                             $time, exp_r.colour, exp_r.depth, exp_r.written);
                    $display("%0t:          actual   colour=%h depth=%h written=%0d",
                             $time, got_r.colour, got_r.depth, got_r.written);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench import dtsr_pkg::*;;

    localparam longint CYCLE_LIMIT = 64'd100_000_000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [31:0] top_row, bottom_row;
    logic [31:0] left_x, left_x_slope, left_z, left_z_slope;
    logic [31:0] right_x, right_x_slope, right_z, right_z_slope;
    logic [7:0]  shade;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  pixel_colour;
    logic [31:0] pixel_depth;
    logic [16:0] pixels_written;
    int          fail_count;
    int          pending;
    int          pixels_total;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          requests_sent;
    longint      cycle_count;

    depth_tested_span_rasterizer i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_op(op), .i_top_row(top_row), .i_bottom_row(bottom_row),
        .i_left_x(left_x), .i_left_x_slope(left_x_slope),
        .i_left_z(left_z), .i_left_z_slope(left_z_slope),
        .i_right_x(right_x), .i_right_x_slope(right_x_slope),
        .i_right_z(right_z), .i_right_z_slope(right_z_slope),
        .i_shade(shade),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_pixel_colour(pixel_colour), .o_pixel_depth(pixel_depth),
        .o_pixels_written(pixels_written)
    );

    span_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_op(op), .i_top_row(top_row), .i_bottom_row(bottom_row),
        .i_left_x(left_x), .i_left_x_slope(left_x_slope),
        .i_left_z(left_z), .i_left_z_slope(left_z_slope),
        .i_right_x(right_x), .i_right_x_slope(right_x_slope),
        .i_right_z(right_z), .i_right_z_slope(right_z_slope),
        .i_shade(shade),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_pixel_colour(pixel_colour), .i_pixel_depth(pixel_depth),
        .i_pixels_written(pixels_written),
        .o_fail_count(fail_count), .o_pending(pending), .o_pixels_total(pixels_total)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        op = OP_NOP;
        {top_row, bottom_row, left_x, left_x_slope, left_z, left_z_slope} = '0;
        {right_x, right_x_slope, right_z, right_z_slope, shade} = '0;
        send_idle_pct = 26;
        recv_idle_pct = 54;
        requests_sent = 0;
        cycle_count = 0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[depth_tested_span_rasterizer] ERROR");
            $finish;
        end
    end

    task automatic send_request(input t_op req_op,
                                input logic [31:0] y1, y2, lx, lxs, lz, lzs,
                                input logic [31:0] rx, rxs, rz, rzs, input logic [7:0] g);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= req_op;
        top_row <= y1; bottom_row <= y2;
        left_x <= lx; left_x_slope <= lxs; left_z <= lz; left_z_slope <= lzs;
        right_x <= rx; right_x_slope <= rxs; right_z <= rz; right_z_slope <= rzs;
        shade <= g;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_read(input logic [31:0] y, input logic [31:0] x);
        send_request(OP_READ, y, $urandom, x, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, 8'($urandom));
    endtask

    function automatic logic [31:0] rand_q16(input int lo, input int hi);
        return {16'($signed(lo + int'($urandom_range(hi - lo)))), 16'($urandom)};
    endfunction

    task automatic send_random_draw();
        logic [31:0] y1, lx, rx;
        int rows;
        int kind;
        kind = $urandom_range(9);
        rows = $urandom_range(5);
        y1 = rand_q16(-4, 243);
        lx = rand_q16(-10, 325);
        rx = lx + {16'($urandom_range(40)), 16'($urandom)};
        if (kind == 0) begin
            send_request(OP_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom));
        end else if (kind == 1) begin
            send_request(OP_DRAW, y1, y1 - 32'h10000, lx, $urandom, $urandom, $urandom,
                         rx, $urandom, $urandom, $urandom, 8'($urandom));
        end else begin
            send_request(OP_DRAW, y1, y1 + {16'(rows), 16'($urandom)}, lx,
                         32'($signed($urandom_range(0, 262144)) - 131072), $urandom,
                         $urandom, rx,
                         32'($signed($urandom_range(0, 262144)) - 131072), $urandom,
                         $urandom, 8'($urandom));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_request(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 8'h00);
        send_request(OP_NOP, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 8'hFF);
        send_request(OP_DRAW, 32'h0, 32'h0009_8000, 32'h0000_8000, 32'h0000_4000,
                     32'h0001_0000, 32'h0000_1000, 32'h0010_0000, 32'h0000_8000,
                     32'h0010_0000, 32'hFFFF_F000, 8'hFF);
        send_request(OP_DRAW, 32'h0, 32'h0009_0000, 32'h0, 32'h0, 32'h8000_0000, 32'h0,
                     32'h0014_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 8'hA5);
        send_request(OP_DRAW, 32'h0005_0000, 32'h0004_0000, '0, '0, '0, '0,
                     32'h0010_0000, '0, '0, '0, 8'h12);
        send_request(OP_DRAW, 32'h0002_0000, 32'h0003_0000, 32'h0020_0000, 32'h0,
                     32'h0, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 8'h34);
        send_request(OP_DRAW, 32'hFFFD_0000, 32'h0002_0000, 32'hFFF0_0000, 32'h0,
                     32'hFFFF_0000, 32'h0, 32'h0003_0000, 32'h0, 32'h8000_0000,
                     32'h0, 8'h80);
        send_request(OP_DRAW, 32'h00EE_0000, 32'h7FFF_FFFF, 32'h013D_0000, 32'h0,
                     32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 8'h40);
        send_request(OP_DRAW, 32'h0050_0000, 32'h0050_0000, 32'h0, 32'h0,
                     32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0, 32'h8000_0000,
                     32'h0, 8'h7F);
        send_read(32'h0000_8000, 32'h0001_0000);
        send_read(32'h0, 32'h0);
        send_read(32'h00EF_FFFF, 32'h013F_FFFF);
        send_read(32'h00F0_0000, 32'h0);
        send_read(32'h0, 32'h0140_0000);
        send_read(32'h8000_0000, 32'h8000_0000);
        send_read(32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_read(32'h0001_0000, 32'h0005_0000);
        send_read(32'h0050_0000, 32'h0);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 54;
                recv_idle_pct = 26;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int i = 0; i < 27; i++) begin
                if (i == 13) wait_drained();
                case ($urandom_range(9))
                    0: send_request(OP_NOP, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, 8'($urandom));
                    1, 2, 3: send_read(rand_q16(-2, 241), rand_q16(-2, 321));
                    default: send_random_draw();
                endcase
            end
            if (phase == 1)
                send_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, $urandom,
                             8'($urandom));
        end

        wait_drained();
        repeat (200) @(posedge clk);
        $display("run covered %0d requests (clear, draw, read, nop) under three idle mixes",
                 requests_sent);
        $display("draws passed the depth test on %0d pixels in total", pixels_total);
        if (fail_count == 0) begin
            $display("[depth_tested_span_rasterizer] OK");
        end else begin
            $display("[depth_tested_span_rasterizer] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/dtsr_pkg.sv
hdl/dtsr_ram.sv
hdl/dtsr_div.sv
hdl/dtsr_datapath.sv
hdl/dtsr_ctrl.sv
hdl/depth_tested_span_rasterizer.sv
hdl/dtsr_checker.sv
verif/span_checker.sv
verif/testbench.sv
